// ----- rtl/umps_pkg.sv -----
`default_nettype none

package umps_pkg;

    localparam int SYSEX_BYTES = 128;
    localparam int ROWS        = (SYSEX_BYTES + 2) / 3;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWC_W      = $clog2(ROWS + 1);
    localparam int FILL_W      = $clog2(SYSEX_BYTES + 1);

    localparam int ADDR_W      = 3;
    localparam int REG_IDX_W   = ADDR_W - 2;
    localparam int DATA_W      = 32;

    localparam logic [REG_IDX_W-1:0] REG_DROP_AS = '0;

    localparam logic [3:0] CIN_TWO_BYTE   = 4'h2;
    localparam logic [3:0] CIN_SYSEX      = 4'h4;
    localparam logic [3:0] CIN_ONE_BYTE   = 4'h5;
    localparam logic [3:0] CIN_END_TWO    = 4'h6;
    localparam logic [3:0] CIN_END_THREE  = 4'h7;
    localparam logic [3:0] CIN_PROG_CHG   = 4'hC;
    localparam logic [3:0] CIN_CHAN_PRESS = 4'hD;

    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] ACTIVE_SENSE = 8'hFE;

    localparam logic STATUS_DATA = 1'b0;
    localparam logic STATUS_OVF  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic drop_active_sensing;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/usb_midi_packet_to_stream_core.sv -----
`default_nettype none

// USB-MIDI event packet decoder. Channel and system common packets produce one
// result in the cycle after acceptance. SysEx packets are stored three bytes per
// row in a single-port-read memory; the closing packet is held in a tail
// register and the message is then replayed as 3-byte chunks, one per stored
// row (memory read, then output load once the output register is free), then
// the tail chunk. A SysEx that ran past SYSEX_BYTES gives a single overflow
// result instead. A new packet is taken only between messages, when the output
// register is empty or being read.
module usb_midi_packet_to_stream_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [3:0]                  i_code_index,
    input  wire logic [7:0]                  i_first_byte,
    input  wire logic [7:0]                  i_second_byte,
    input  wire logic [7:0]                  i_third_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [7:0]                  o_out_first,
    output logic      [7:0]                  o_out_second,
    output logic      [7:0]                  o_out_third,
    output logic      [1:0]                  o_byte_count,
    output logic                             o_last_chunk,
    output logic                             o_status,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [umps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [umps_pkg::DATA_W-1:0] pwdata,
    output logic      [umps_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import umps_pkg::*;

    t_cfg cfg;

    umps_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // control
    t_state              r_state,      n_state;
    logic                r_collecting, n_collecting;
    logic                r_overflowed, n_overflowed;
    logic [FILL_W-1:0]   r_fill,       n_fill;
    logic [ROWC_W-1:0]   r_row,        n_row;
    logic [ROWC_W-1:0]   r_rd_row,     n_rd_row;
    logic                r_out_valid,  n_out_valid;

    // payload
    logic [23:0]         r_mem [ROWS];
    logic [23:0]         r_rdata;
    logic [23:0]         r_tail,       n_tail;
    logic [1:0]          r_tail_len,   n_tail_len;
    logic [7:0]          r_out_first,  n_out_first;
    logic [7:0]          r_out_second, n_out_second;
    logic [7:0]          r_out_third,  n_out_third;
    logic [1:0]          r_out_count,  n_out_count;
    logic                r_out_last,   n_out_last;
    logic                r_out_status, n_out_status;

    logic                slot_free;
    logic                in_acc;
    logic                cin_is_sx, is_start, is_end;
    logic [1:0]          end_len, msg_len;
    logic [FILL_W-1:0]   fill_base;
    logic [ROWC_W-1:0]   row_base;
    logic [FILL_W:0]     fill_add3, fill_addend;
    logic [23:0]         pkt_bytes, end_bytes, msg_bytes;
    logic                load_out, tail_ld, mem_we, mem_re;
    logic [ROW_W-1:0]    mem_waddr;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && slot_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign pkt_bytes = {i_third_byte, i_second_byte, i_first_byte};
    assign cin_is_sx = (i_code_index == CIN_SYSEX);
    assign is_start  = cin_is_sx && (i_first_byte == SYSEX_START);
    assign is_end    = (i_code_index == CIN_END_TWO) || (i_code_index == CIN_END_THREE)
                    || ((i_code_index == CIN_ONE_BYTE) && (i_first_byte == SYSEX_END));

    always_comb begin
        case (i_code_index)
            CIN_END_THREE: end_len = 2'd3;
            CIN_END_TWO:   end_len = 2'd2;
            default:       end_len = 2'd1;
        endcase
        case (i_code_index)
            CIN_TWO_BYTE, CIN_PROG_CHG, CIN_CHAN_PRESS: msg_len = 2'd2;
            CIN_ONE_BYTE:                               msg_len = 2'd1;
            default:                                    msg_len = 2'd3;
        endcase
    end

    always_comb begin
        end_bytes = pkt_bytes;
        if (end_len < 2'd3) end_bytes[23:16] = '0;
        if (end_len < 2'd2) end_bytes[15:8]  = '0;
        msg_bytes = pkt_bytes;
        if (msg_len < 2'd3) msg_bytes[23:16] = '0;
        if (msg_len < 2'd2) msg_bytes[15:8]  = '0;
    end

    assign fill_base   = is_start ? '0 : r_fill;
    assign row_base    = is_start ? '0 : r_row;
    assign fill_add3   = {1'b0, fill_base} + (FILL_W+1)'(3);
    assign fill_addend = {1'b0, r_fill} + (FILL_W+1)'(end_len);
    assign mem_waddr   = row_base[ROW_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_collecting = r_collecting;
        n_overflowed = r_overflowed;
        n_fill       = r_fill;
        n_row        = r_row;
        n_rd_row     = r_rd_row;
        n_tail       = r_tail;
        n_tail_len   = r_tail_len;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_third  = r_out_third;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        load_out     = 1'b0;
        tail_ld      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (cin_is_sx) begin
                        if (is_start || r_collecting) begin
                            n_collecting = 1'b1;
                            if (is_start) begin
                                n_overflowed = 1'b0;
                            end
                            if (fill_add3 <= (FILL_W+1)'(SYSEX_BYTES)) begin
                                mem_we = 1'b1;
                                n_row  = ROWC_W'(row_base + 1'b1);
                                n_fill = fill_add3[FILL_W-1:0];
                            end else begin
                                n_overflowed = 1'b1;
                            end
                        end
                    end else if (is_end) begin
                        if (r_collecting) begin
                            n_collecting = 1'b0;
                            n_overflowed = 1'b0;
                            n_fill       = '0;
                            if (r_overflowed || (fill_addend > (FILL_W+1)'(SYSEX_BYTES))) begin
                                load_out     = 1'b1;
                                n_out_first  = '0;
                                n_out_second = '0;
                                n_out_third  = '0;
                                n_out_count  = 2'd0;
                                n_out_last   = 1'b1;
                                n_out_status = STATUS_OVF;
                            end else begin
                                tail_ld    = 1'b1;
                                n_tail     = end_bytes;
                                n_tail_len = end_len;
                                n_rd_row   = '0;
                                n_state    = ST_READ;
                            end
                        end
                    end else if (!((msg_len == 2'd1) && (i_first_byte == ACTIVE_SENSE)
                                   && cfg.drop_active_sensing)) begin
                        load_out     = 1'b1;
                        n_out_first  = msg_bytes[7:0];
                        n_out_second = msg_bytes[15:8];
                        n_out_third  = msg_bytes[23:16];
                        n_out_count  = msg_len;
                        n_out_last   = 1'b1;
                        n_out_status = STATUS_DATA;
                    end
                end
            end
            ST_READ: begin
                mem_re  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    load_out     = 1'b1;
                    n_out_first  = r_rdata[7:0];
                    n_out_second = r_rdata[15:8];
                    n_out_third  = r_rdata[23:16];
                    n_out_count  = 2'd3;
                    n_out_last   = 1'b0;
                    n_out_status = STATUS_DATA;
                    n_rd_row     = ROWC_W'(r_rd_row + 1'b1);
                    n_state      = (ROWC_W'(r_rd_row + 1'b1) == r_row) ? ST_TAIL : ST_READ;
                end
            end
            ST_TAIL: begin
                if (slot_free) begin
                    load_out     = 1'b1;
                    n_out_first  = r_tail[7:0];
                    n_out_second = r_tail[15:8];
                    n_out_third  = r_tail[23:16];
                    n_out_count  = r_tail_len;
                    n_out_last   = 1'b1;
                    n_out_status = STATUS_DATA;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !i_out_ready) || load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_collecting <= 1'b0;
            r_overflowed <= 1'b0;
            r_fill       <= '0;
            r_row        <= '0;
            r_rd_row     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_collecting <= n_collecting;
            r_overflowed <= n_overflowed;
            r_fill       <= n_fill;
            r_row        <= n_row;
            r_rd_row     <= n_rd_row;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= pkt_bytes;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_rd_row[ROW_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_ld) begin
            r_tail     <= n_tail;
            r_tail_len <= n_tail_len;
        end
        if (load_out) begin
            r_out_first  <= n_out_first;
            r_out_second <= n_out_second;
            r_out_third  <= n_out_third;
            r_out_count  <= n_out_count;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;
    assign o_out_third  = r_out_third;
    assign o_byte_count = r_out_count;
    assign o_last_chunk = r_out_last;
    assign o_status     = r_out_status;

    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_EMIT) |-> (r_rd_row < r_row))
        else $error("replay row past stored rows");

    a_fill_tracks_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_collecting && !r_overflowed) |->
            ((FILL_W+ROWC_W+2)'(r_fill) ==
             (FILL_W+ROWC_W+2)'(r_row) * (FILL_W+ROWC_W+2)'(3)))
        else $error("fill count out of step with row count");

    a_ovf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_OVF) |->
            (r_out_count == 2'd0 && r_out_last))
        else $error("malformed overflow report");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("packet taken during replay");

endmodule

`default_nettype wire

// ----- rtl/umps_apb_regs.sv -----
`default_nettype none

module umps_apb_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [umps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [umps_pkg::DATA_W-1:0] pwdata,
    output logic      [umps_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output umps_pkg::t_cfg                   o_cfg
);
    import umps_pkg::*;

    logic r_drop_as;
    logic n_drop_as;
    logic hit;

    assign hit    = (paddr[ADDR_W-1:2] == REG_DROP_AS);
    assign pready = 1'b1;

    always_comb begin
        n_drop_as = r_drop_as;
        if (psel && penable && pwrite && hit) begin
            n_drop_as = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_as <= 1'b0;
        end else begin
            r_drop_as <= n_drop_as;
        end
    end

    assign prdata                    = hit ? {{(DATA_W-1){1'b0}}, r_drop_as} : '0;
    assign o_cfg.drop_active_sensing = r_drop_as;

endmodule

`default_nettype wire

// ----- tb/usb_midi_packet_to_stream_core_chk.sv -----
`default_nettype none

module usb_midi_packet_to_stream_core_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [3:0]                  i_code_index,
    input  wire logic [7:0]                  i_first_byte,
    input  wire logic [7:0]                  i_second_byte,
    input  wire logic [7:0]                  i_third_byte,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [7:0]                  i_out_first,
    input  wire logic [7:0]                  i_out_second,
    input  wire logic [7:0]                  i_out_third,
    input  wire logic [1:0]                  i_byte_count,
    input  wire logic                        i_last_chunk,
    input  wire logic                        i_status,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [umps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [umps_pkg::DATA_W-1:0] pwdata,
    input  wire logic                        pready,
    output int                               o_pending,
    output int                               o_fail_count,
    output int                               o_chunks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import umps_pkg::*;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;
        logic       last;
        logic       status;
    } t_chunk;

    t_chunk     chunks_due[$];
    logic [7:0] sx_mem [SYSEX_BYTES];
    int         sx_fill = 0;
    logic       sx_open = 1'b0;
    logic       sx_over = 1'b0;
    logic       drop_as = 1'b0;
    int         fails   = 0;
    int         checked = 0;

    task automatic stash_byte(input logic [7:0] b);
        if (sx_fill < SYSEX_BYTES) begin
            sx_mem[sx_fill] = b;
            sx_fill++;
        end else begin
            sx_over = 1'b1;
        end
    endtask

    task automatic decode_packet(input logic [3:0] cin, input logic [7:0] b0,
                                 input logic [7:0] b1, input logic [7:0] b2);
        logic [7:0] pkt [3];
        t_chunk     ch;
        int         nb;
        int         off;
        pkt[0] = b0;
        pkt[1] = b1;
        pkt[2] = b2;
        if (cin == CIN_SYSEX) begin
            if (b0 == SYSEX_START) begin
                sx_fill = 0;
                sx_over = 1'b0;
                sx_open = 1'b1;
                for (int i = 0; i < 3; i++) stash_byte(pkt[i]);
            end else if (sx_open) begin
                for (int i = 0; i < 3; i++) stash_byte(pkt[i]);
            end
        end else if (cin == CIN_END_TWO || cin == CIN_END_THREE ||
                     (cin == CIN_ONE_BYTE && b0 == SYSEX_END)) begin
            if (sx_open) begin
                nb = (cin == CIN_END_THREE) ? 3 : (cin == CIN_END_TWO) ? 2 : 1;
                for (int i = 0; i < nb; i++) stash_byte(pkt[i]);
                if (sx_over) begin
                    ch = '0;
                    ch.last = 1'b1;
                    ch.status = STATUS_OVF;
                    chunks_due.push_back(ch);
                end else begin
                    off = 0;
                    while (off < sx_fill) begin
                        nb = sx_fill - off;
                        if (nb > 3) nb = 3;
                        ch = '0;
                        ch.b0 = sx_mem[off];
                        if (nb > 1) ch.b1 = sx_mem[off + 1];
                        if (nb > 2) ch.b2 = sx_mem[off + 2];
                        ch.count = nb[1:0];
                        off += nb;
                        ch.last = (off >= sx_fill);
                        ch.status = STATUS_DATA;
                        chunks_due.push_back(ch);
                    end
                end
                sx_open = 1'b0;
                sx_over = 1'b0;
                sx_fill = 0;
            end
        end else begin
            if (cin == CIN_TWO_BYTE || cin == CIN_PROG_CHG || cin == CIN_CHAN_PRESS)
                nb = 2;
            else if (cin == CIN_ONE_BYTE)
                nb = 1;
            else
                nb = 3;
            if (!(nb == 1 && b0 == ACTIVE_SENSE && drop_as)) begin
                ch = '0;
                ch.b0 = b0;
                if (nb > 1) ch.b1 = b1;
                if (nb > 2) ch.b2 = b2;
                ch.count = nb[1:0];
                ch.last = 1'b1;
                ch.status = STATUS_DATA;
                chunks_due.push_back(ch);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_chunk want;
        if (!i_rst_n) begin
            sx_fill = 0;
            sx_open = 1'b0;
            sx_over = 1'b0;
            drop_as = 1'b0;
            chunks_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (chunks_due.size() == 0) begin
                    $error("unexpected transaction: bytes %0h %0h %0h count %0d status %0d",
                           i_out_first, i_out_second, i_out_third, i_byte_count, i_status);
                    fails++;
                end else begin
                    want = chunks_due.pop_front();
                    check_field("out_first", want.b0, i_out_first);
                    check_field("out_second", want.b1, i_out_second);
                    check_field("out_third", want.b2, i_out_third);
                    check_field("byte_count", {6'd0, want.count}, {6'd0, i_byte_count});
                    check_field("last_chunk", {7'd0, want.last}, {7'd0, i_last_chunk});
                    check_field("status", {7'd0, want.status}, {7'd0, i_status});
                end
            end
            if (i_in_valid && i_in_ready)
                decode_packet(i_code_index, i_first_byte, i_second_byte, i_third_byte);
            if (psel && penable && pwrite && pready &&
                paddr[umps_pkg::ADDR_W-1:2] == REG_DROP_AS)
                drop_as = pwdata[0];
        end
        o_pending        <= chunks_due.size();
        o_fail_count     <= fails;
        o_chunks_checked <= checked;
    end

endmodule

`default_nettype wire

// ----- tb/usb_midi_packet_to_stream_core_tb.sv -----
`default_nettype none

module usb_midi_packet_to_stream_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import umps_pkg::*;

    localparam logic [3:0] CIN_MISC        = 4'h0;
    localparam logic [3:0] CIN_CABLE_EVT   = 4'h1;
    localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
    localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
    localparam logic [3:0] CIN_SINGLE_BYTE = 4'hF;

    localparam int IDLE_PCT    = 21;
    localparam int LONG_HOLD   = 250;
    localparam int TAIL_CYCLES = 100;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [3:0]        i_code_index;
    logic [7:0]        i_first_byte;
    logic [7:0]        i_second_byte;
    logic [7:0]        i_third_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [7:0]        o_out_first;
    logic [7:0]        o_out_second;
    logic [7:0]        o_out_third;
    logic [1:0]        o_byte_count;
    logic              o_last_chunk;
    logic              o_status;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int pending_chunks;
    int fail_count;
    int chunks_checked;

    bit no_idle     = 1'b0;
    bit hold_armed  = 1'b0;
    int items_sent  = 0;
    int sysex_msgs  = 0;
    int long_sysex  = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    usb_midi_packet_to_stream_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_code_index (i_code_index),
        .i_first_byte (i_first_byte),
        .i_second_byte(i_second_byte),
        .i_third_byte (i_third_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_first  (o_out_first),
        .o_out_second (o_out_second),
        .o_out_third  (o_out_third),
        .o_byte_count (o_byte_count),
        .o_last_chunk (o_last_chunk),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    usb_midi_packet_to_stream_core_chk chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_code_index    (i_code_index),
        .i_first_byte    (i_first_byte),
        .i_second_byte   (i_second_byte),
        .i_third_byte    (i_third_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_first     (o_out_first),
        .i_out_second    (o_out_second),
        .i_out_third     (o_out_third),
        .i_byte_count    (o_byte_count),
        .i_last_chunk    (o_last_chunk),
        .i_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_pending       (pending_chunks),
        .o_fail_count    (fail_count),
        .o_chunks_checked(chunks_checked)
    );

    function automatic logic [7:0] rand_data();
        return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
    endfunction

    task automatic send_pkt(input logic [3:0] cin, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_code_index  <= cin;
        i_first_byte  <= b0;
        i_second_byte <= b1;
        i_third_byte  <= b2;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, drain every predicted chunk, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chunks != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sysex(input int n_cont, input logic [3:0] end_cin);
        logic [7:0] lead;
        send_pkt(CIN_SYSEX, SYSEX_START, rand_data(), rand_data());
        for (int k = 0; k < n_cont; k++) begin
            lead = rand_data();
            if (lead == SYSEX_START) lead = 8'h00;
            send_pkt(CIN_SYSEX, lead, rand_data(), rand_data());
        end
        lead = (end_cin == CIN_ONE_BYTE) ? SYSEX_END : rand_data();
        send_pkt(end_cin, lead, rand_data(), rand_data());
        sysex_msgs++;
        if (n_cont >= 40) long_sysex++;
    endtask

    task automatic run_random(input int n_items, input bit quiet_first);
        int         first;
        int         pick;
        int         n_cont;
        logic [3:0] cin;
        logic [3:0] end_cin;
        logic [7:0] b0;
        first = items_sent;
        while (items_sent - first < n_items) begin
            no_idle = quiet_first && (items_sent - first < n_items / 2);
            pick = $urandom_range(99);
            // near the store size: exact fill, one short, and overflow
            n_cont = ($urandom_range(7) == 0) ? $urandom_range(40, 43) : $urandom_range(6);
            case ($urandom_range(2))
                0: end_cin = CIN_ONE_BYTE;
                1: end_cin = CIN_END_TWO;
                default: end_cin = CIN_END_THREE;
            endcase
            if (pick < 45) begin
                send_sysex(n_cont, end_cin);
            end else if (pick < 75) begin
                cin = ($urandom_range(4) == 0) ? CIN_ONE_BYTE : 4'($urandom_range(15));
                if (cin == CIN_SYSEX || cin == CIN_END_TWO || cin == CIN_END_THREE)
                    cin = CIN_NOTE_ON;
                b0 = ($urandom_range(3) == 0) ? ACTIVE_SENSE : 8'($urandom_range(255));
                if (cin == CIN_ONE_BYTE && b0 == SYSEX_END) b0 = ACTIVE_SENSE;
                send_pkt(cin, b0, rand_data(), rand_data());
            end else if (pick < 90) begin
                case ($urandom_range(3))
                    0: b0 = SYSEX_START;
                    1: b0 = SYSEX_END;
                    2: b0 = ACTIVE_SENSE;
                    default: b0 = 8'($urandom_range(255));
                endcase
                send_pkt(4'($urandom_range(15)), b0, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            end else begin
                // abandoned SysEx, then a restart
                send_pkt(CIN_SYSEX, SYSEX_START, rand_data(), rand_data());
                repeat ($urandom_range(3))
                    send_pkt(CIN_SYSEX, 8'($urandom_range(127)), rand_data(), rand_data());
                send_sysex($urandom_range(4), end_cin);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_code_index  <= '0;
        i_first_byte  <= '0;
        i_second_byte <= '0;
        i_third_byte  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_write(REG_DROP_AS, 32'd0);

        send_pkt(CIN_NOTE_ON, 8'h90, 8'h3C, 8'h7F);
        send_pkt(CIN_TWO_BYTE, 8'hF3, 8'h05, 8'hAA);
        send_pkt(CIN_PROG_CHG, 8'hC0, 8'h7F, 8'hFF);
        send_pkt(CIN_CHAN_PRESS, 8'hDF, 8'h00, 8'hFF);
        send_pkt(CIN_ONE_BYTE, 8'hF8, 8'hFF, 8'hFF);
        send_pkt(CIN_ONE_BYTE, ACTIVE_SENSE, 8'h00, 8'h00);
        send_pkt(CIN_MISC, 8'h00, 8'h00, 8'h00);
        send_pkt(CIN_CABLE_EVT, 8'hFF, 8'hFF, 8'hFF);
        send_pkt(CIN_SINGLE_BYTE, ACTIVE_SENSE, 8'h00, 8'h00);
        // ends and continuation with no SysEx open
        send_pkt(CIN_END_TWO, 8'h01, SYSEX_END, 8'h00);
        send_pkt(CIN_END_THREE, 8'h01, 8'h02, SYSEX_END);
        send_pkt(CIN_ONE_BYTE, SYSEX_END, 8'h00, 8'h00);
        send_pkt(CIN_SYSEX, 8'h7E, 8'h01, 8'h02);
        // zero bytes must be kept
        send_pkt(CIN_SYSEX, SYSEX_START, 8'h00, 8'h7E);
        send_pkt(CIN_SYSEX, 8'h00, 8'h00, 8'h00);
        send_pkt(CIN_END_THREE, 8'h01, 8'h02, SYSEX_END);
        send_pkt(CIN_SYSEX, SYSEX_START, 8'h7D, 8'h01);
        send_pkt(CIN_ONE_BYTE, SYSEX_END, 8'h55, 8'hAA);
        // restart in the middle of a SysEx
        send_pkt(CIN_SYSEX, SYSEX_START, 8'h11, 8'h22);
        send_pkt(CIN_SYSEX, SYSEX_START, 8'h33, 8'h44);
        send_pkt(CIN_END_TWO, 8'h55, SYSEX_END, 8'h99);
        // channel message inside an open SysEx
        send_pkt(CIN_SYSEX, SYSEX_START, 8'h01, 8'h02);
        send_pkt(CIN_NOTE_OFF, 8'h80, 8'h40, 8'h00);
        send_pkt(CIN_END_TWO, 8'h03, SYSEX_END, 8'h00);

        settle();
        apb_write(REG_DROP_AS, 32'd1);
        send_pkt(CIN_ONE_BYTE, ACTIVE_SENSE, 8'h12, 8'h34);
        send_pkt(CIN_TWO_BYTE, ACTIVE_SENSE, 8'h12, 8'h34);
        hold_armed = 1'b1;
        run_random(85, 1'b0);

        settle();
        apb_write(REG_DROP_AS, 32'd0);
        run_random(75, 1'b1);

        settle();
        apb_write(REG_DROP_AS, 32'd1);
        run_random(55, 1'b0);

        settle();
        $display("covered %0d packets, %0d SysEx messages (%0d near or past the store size)",
                 items_sent, sysex_msgs, long_sysex);
        $display("checked %0d output chunks with Active Sensing drop both off and on",
                 chunks_checked);
        if (fail_count == 0) begin
            $display("[usb_midi_packet_to_stream_core] OK");
        end else begin
            $display("[usb_midi_packet_to_stream_core] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d chunks outstanding", pending_chunks);
        $display("[usb_midi_packet_to_stream_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
